// ----- rtl/core/sprite_chain_attribute_walker_top_defines.svh -----
// Assertion macros shared by the sprite chain attribute walker.
`ifndef SPRITE_CHAIN_ATTRIBUTE_WALKER_TOP_DEFINES_SVH
`define SPRITE_CHAIN_ATTRIBUTE_WALKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define SCAW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define SCAW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/scaw_pkg.sv -----
package scaw_pkg;

    // Coordinate, zoom, rounding and flip-bit constants.
    localparam int unsigned COORD_W    = 10;
    localparam int unsigned POS_W      = 14;
    localparam int unsigned ACC_W      = 17;
    localparam logic [8:0]  ZOOM_UNITY = 9'h100;
    localparam logic [7:0]  BYTE_MAX   = 8'hff;
    localparam logic [3:0]  ROUND_UP   = 4'hf;
    localparam int unsigned FLIPX_BIT  = 14;
    localparam int unsigned FLIPY_BIT  = 15;

    // One sprite-list entry.
    typedef struct packed {
        logic [15:0] tile_word;
        logic [15:0] attribute_word;
        logic [15:0] xpos_word;
        logic [15:0] ypos_word;
        logic [15:0] zoom_word;
        logic [15:0] size_word;
    } item_t;

    // One draw command.
    typedef struct packed {
        logic [15:0]       tile_number;
        logic [9:0]        colour_offset;
        logic              mirror_x;
        logic              mirror_y;
        logic signed [13:0] screen_x;
        logic signed [13:0] screen_y;
        logic [4:0]        width_px;
        logic [4:0]        height_px;
        logic              use_zoom;
    } cmd_t;

    // Chain walk status seen by the top level.
    typedef struct packed {
        logic       active;
        logic [8:0] row_index;
        logic [7:0] row_last;
        logic [8:0] column_index;
        logic [7:0] column_last;
    } walk_status_t;

endpackage

// ----- rtl/core/scaw_walker.sv -----
module scaw_walker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  scaw_pkg::item_t        item,
    output scaw_pkg::cmd_t         cmd,
    output scaw_pkg::walk_status_t status
);
    import scaw_pkg::*;

    logic               active_reg, active_next;
    logic [9:0]         origin_x_reg, origin_x_next;
    logic [9:0]         origin_y_reg, origin_y_next;
    logic [7:0]         zoom_x_reg, zoom_x_next;
    logic [7:0]         zoom_y_reg, zoom_y_next;
    logic [8:0]         column_reg, column_next;
    logic [8:0]         row_reg, row_next;
    logic [7:0]         column_last_reg, column_last_next;
    logic [7:0]         row_last_reg, row_last_next;
    logic [ACC_W-1:0]   acc_x_reg, acc_x_next;
    logic [ACC_W-1:0]   acc_y_reg, acc_y_next;

    logic               start;
    logic               eff_active;
    logic [9:0]         eff_ox, eff_oy;
    logic [7:0]         eff_zx, eff_zy;
    logic [8:0]         eff_col, eff_row;
    logic [7:0]         eff_col_last, eff_row_last;
    logic [ACC_W-1:0]   eff_acc_x, eff_acc_y;
    logic [7:0]         zx_in, zy_in;
    logic [7:0]         k_x, k_y;
    logic [ACC_W-1:0]   sum_x0, sum_x1, sum_y0, sum_y1;
    logic [12:0]        off_x0, off_x1, off_y0, off_y1;
    logic [12:0]        size_x, size_y;
    logic [8:0]         span_x, span_y;
    logic [8:0]         row_inc, col_inc;
    logic               row_wrap, col_done;

    // A nonzero size word opens a chain only when none is running.
    assign zx_in      = item.zoom_word[15:8];
    assign zy_in      = item.zoom_word[7:0];
    assign start      = (item.size_word != 16'h0000) && !active_reg;
    assign eff_active = active_reg || start;

    // Chain parameters as seen by this entry: fresh from the entry on a start.
    assign eff_ox       = start ? item.xpos_word[COORD_W-1:0] : origin_x_reg;
    assign eff_oy       = start ? item.ypos_word[COORD_W-1:0] : origin_y_reg;
    assign eff_zx       = start ? zx_in : zoom_x_reg;
    assign eff_zy       = start ? zy_in : zoom_y_reg;
    assign eff_col      = start ? 9'd0 : column_reg;
    assign eff_row      = start ? 9'd0 : row_reg;
    assign eff_col_last = start ? item.size_word[15:8] : column_last_reg;
    assign eff_row_last = start ? item.size_word[7:0] : row_last_reg;
    assign eff_acc_x    = start ? '0 : acc_x_reg;
    assign eff_acc_y    = start ? '0 : acc_y_reg;

    // Cell offsets: the accumulators hold index times step, rounded up by sixteenths.
    assign k_x    = BYTE_MAX - eff_zx;
    assign k_y    = BYTE_MAX - eff_zy;
    assign sum_x0 = eff_acc_x + ACC_W'(ROUND_UP);
    assign sum_x1 = sum_x0 + ACC_W'(k_x);
    assign sum_y0 = eff_acc_y + ACC_W'(ROUND_UP);
    assign sum_y1 = sum_y0 + ACC_W'(k_y);
    assign off_x0 = sum_x0[ACC_W-1:4];
    assign off_x1 = sum_x1[ACC_W-1:4];
    assign off_y0 = sum_y0[ACC_W-1:4];
    assign off_y1 = sum_y1[ACC_W-1:4];
    assign size_x = off_x1 - off_x0;
    assign size_y = off_y1 - off_y0;

    // Single sprite size from the entry's own zoom.
    assign span_x = ZOOM_UNITY - {1'b0, zx_in};
    assign span_y = ZOOM_UNITY - {1'b0, zy_in};

    // Build the draw command.
    always_comb
    begin
        cmd.tile_number   = item.tile_word;
        cmd.colour_offset = {item.attribute_word[5:0], 4'b0000};
        cmd.mirror_x      = item.attribute_word[FLIPX_BIT];
        cmd.mirror_y      = item.attribute_word[FLIPY_BIT];
        if (eff_active)
        begin
            cmd.screen_x  = {{(POS_W-COORD_W){eff_ox[COORD_W-1]}}, eff_ox}
                            + POS_W'(off_x0);
            cmd.screen_y  = {{(POS_W-COORD_W){eff_oy[COORD_W-1]}}, eff_oy}
                            + POS_W'(off_y0);
            cmd.width_px  = size_x[4:0];
            cmd.height_px = size_y[4:0];
            cmd.use_zoom  = (eff_zx != 8'h00) || (eff_zy != 8'h00);
        end
        else
        begin
            cmd.screen_x  = {{(POS_W-COORD_W){item.xpos_word[COORD_W-1]}},
                             item.xpos_word[COORD_W-1:0]};
            cmd.screen_y  = {{(POS_W-COORD_W){item.ypos_word[COORD_W-1]}},
                             item.ypos_word[COORD_W-1:0]};
            cmd.width_px  = span_x[8:4];
            cmd.height_px = span_y[8:4];
            cmd.use_zoom  = (zx_in != 8'h00) || (zy_in != 8'h00);
        end
    end

    // Grid walk: rows inside each column, the chain ends past the last column.
    assign row_inc  = eff_row + 9'd1;
    assign row_wrap = row_inc > {1'b0, eff_row_last};
    assign col_inc  = eff_col + 9'd1;
    assign col_done = col_inc > {1'b0, eff_col_last};

    always_comb
    begin
        active_next      = active_reg;
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        zoom_x_next      = zoom_x_reg;
        zoom_y_next      = zoom_y_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        column_last_next = column_last_reg;
        row_last_next    = row_last_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        if (step && eff_active)
        begin
            origin_x_next    = eff_ox;
            origin_y_next    = eff_oy;
            zoom_x_next      = eff_zx;
            zoom_y_next      = eff_zy;
            column_last_next = eff_col_last;
            row_last_next    = eff_row_last;
            if (row_wrap)
            begin
                row_next    = 9'd0;
                column_next = col_inc;
                acc_y_next  = '0;
                acc_x_next  = eff_acc_x + ACC_W'(k_x);
                active_next = !col_done;
            end
            else
            begin
                row_next    = row_inc;
                column_next = eff_col;
                acc_x_next  = eff_acc_x;
                acc_y_next  = eff_acc_y + ACC_W'(k_y);
                active_next = 1'b1;
            end
        end
    end

    // Chain state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            zoom_x_reg      <= '0;
            zoom_y_reg      <= '0;
            column_reg      <= '0;
            row_reg         <= '0;
            column_last_reg <= '0;
            row_last_reg    <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
        end
        else
        begin
            active_reg      <= active_next;
            origin_x_reg    <= origin_x_next;
            origin_y_reg    <= origin_y_next;
            zoom_x_reg      <= zoom_x_next;
            zoom_y_reg      <= zoom_y_next;
            column_reg      <= column_next;
            row_reg         <= row_next;
            column_last_reg <= column_last_next;
            row_last_reg    <= row_last_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
        end
    end

    assign status.active       = active_reg;
    assign status.row_index    = row_reg;
    assign status.row_last     = row_last_reg;
    assign status.column_index = column_reg;
    assign status.column_last  = column_last_reg;

endmodule

// ----- rtl/core/sprite_chain_attribute_walker_top.sv -----
// Accepted requests pass from the input stage to the result register (m_tvalid).
// Throughput: one request per cycle unless stalled; the input stage and the result
// register advance together, and the chain state is updated once per request in that
// step. A stalled result holds while the input stage still takes one more request.
// Reset (rst_n low, asynchronous) empties both stages and clears the chain state.
module sprite_chain_attribute_walker_top
(
    input  logic        clk,
    input  logic        rst_n,
    // tdata: tile_word, attribute_word, xpos_word, ypos_word, zoom_word, size_word
    input  logic [95:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: tile_number, colour_offset, mirror_x, mirror_y, screen_x, screen_y,
    //        width_px, height_px, use_zoom, zero fill
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import scaw_pkg::*;

    `include "sprite_chain_attribute_walker_top_defines.svh"

    logic         s0_valid_reg, s0_valid_next;
    item_t        s0_item_reg;
    logic         out_valid_reg, out_valid_next;
    cmd_t         out_cmd_reg;
    logic         s_accept;
    logic         advance;
    cmd_t         cmd;
    walk_status_t status;

    // Handshake: the input stage moves into the result register when that is free.
    assign advance  = s0_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s0_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (s_accept)
        begin
            s0_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s0_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s0_item_reg.tile_word      <= s_tdata[15:0];
            s0_item_reg.attribute_word <= s_tdata[31:16];
            s0_item_reg.xpos_word      <= s_tdata[47:32];
            s0_item_reg.ypos_word      <= s_tdata[63:48];
            s0_item_reg.zoom_word      <= s_tdata[79:64];
            s0_item_reg.size_word      <= s_tdata[95:80];
        end
        if (advance)
        begin
            out_cmd_reg <= cmd;
        end
    end

    // Command build and chain walk.
    scaw_walker u_walker
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s0_item_reg),
        .cmd    (cmd),
        .status (status)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000,
                       out_cmd_reg.use_zoom,
                       out_cmd_reg.height_px,
                       out_cmd_reg.width_px,
                       out_cmd_reg.screen_y,
                       out_cmd_reg.screen_x,
                       out_cmd_reg.mirror_y,
                       out_cmd_reg.mirror_x,
                       out_cmd_reg.colour_offset,
                       out_cmd_reg.tile_number};

    // Checks on stage control and the chain walk.
    `SCAW_ASSERT_NOW(a_no_overrun, s0_valid_reg && out_valid_reg && !m_tready, !s_tready, "input stage overrun while result stalled")
    `SCAW_ASSERT_NEXT(a_advance_shows, advance, m_tvalid, "advanced request did not reach the result register")
    `SCAW_ASSERT_NOW(a_grid_bounds, status.active, (status.row_index <= {1'b0, status.row_last}) && (status.column_index <= {1'b0, status.column_last}), "chain walk outside its grid")

endmodule
